// ===== rtl/assert_macros.svh =====
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/rycc_pkg.sv =====
// Types, constants and register indexes of the RGB/YCbCr converter.
package rycc_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int ROW_WIDTH_W = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARSE_CHROMA = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH     = 2'd2;

  // 16.16 JFIF coefficients and offsets, 26-bit signed working width
  localparam int ACC_W = 26;
  localparam logic signed [ACC_W-1:0] K_Y_R    = 26'sd19595;
  localparam logic signed [ACC_W-1:0] K_Y_G    = 26'sd38470;
  localparam logic signed [ACC_W-1:0] K_Y_B    = 26'sd7471;
  localparam logic signed [ACC_W-1:0] OFF_Y    = 26'sd32768;
  localparam logic signed [ACC_W-1:0] K_CB_R   = -26'sd11058;
  localparam logic signed [ACC_W-1:0] K_CB_G   = -26'sd21709;
  localparam logic signed [ACC_W-1:0] K_HALF   = 26'sd32767;
  localparam logic signed [ACC_W-1:0] OFF_C    = 26'sd8421376;
  localparam logic signed [ACC_W-1:0] K_CR_G   = -26'sd27438;
  localparam logic signed [ACC_W-1:0] K_CR_B   = -26'sd5329;
  localparam logic signed [ACC_W-1:0] K_R_CR   = 26'sd91885;
  localparam logic signed [ACC_W-1:0] OFF_R    = -26'sd11728512;
  localparam logic signed [ACC_W-1:0] K_G_CB   = -26'sd22554;
  localparam logic signed [ACC_W-1:0] K_G_CR   = -26'sd46803;
  localparam logic signed [ACC_W-1:0] OFF_G    = 26'sd8910464;
  localparam logic signed [ACC_W-1:0] K_B_CB   = 26'sd116134;
  localparam logic signed [ACC_W-1:0] OFF_B    = -26'sd14832384;

  typedef struct packed {
    logic [7:0] comp0;
    logic [7:0] comp1;
    logic [7:0] comp2;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] res0;
    logic [7:0] res1;
    logic [7:0] res2;
    logic [7:0] alpha_out;
  } pixel_out_t;

  // per-item conversion mode
  typedef struct packed {
    logic inverse;
    logic luma_only;
  } conv_mode_t;

  // raster position parity
  typedef struct packed {
    logic odd_column;
    logic odd_row;
  } parity_t;

endpackage

// ===== rtl/rgb_ycbcr_color_converter.sv =====
// Top level of the RGB/YCbCr pixel converter: channels, pipeline and registers.
//
// Usage
//   pixel channel  : one item per pixel (comp0..comp2, alpha_in), raster order.
//   result channel : one item per pixel (res0..res2, alpha_out), same order.
//   cfg channel    : register writes, index 0 direction, 1 sparse_chroma,
//                    2 row_width; other indexes are ignored. Always ready.
//                    Write only while the pipeline is empty.
// Timing
//   Two register stages: an input register and a result register. An item
//   accepted into the input register passes through the datapath into the
//   result register, which shows it on the result port.
//   Throughput is one item per cycle while result_ready stays high, set by
//   the combinational datapath between the two registers.
// Stalls
//   When result_ready is low and a result is shown, the result register holds;
//   the input register still takes one more item, after which pixel_ready falls.
// Reset
//   rst (synchronous) empties both stages, sets direction to forward,
//   sparse_chroma off, row_width to 1 and the raster position to column 0
//   of an even row.
`include "assert_macros.svh"

module rgb_ycbcr_color_converter
  import rycc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_in_t              pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output pixel_out_t             result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_WIDTH_W-1:0] cfg_data
);

  // configuration registers
  logic                   direction;
  logic                   sparse_chroma;
  logic [ROW_WIDTH_W-1:0] row_width;

  // input stage
  logic       s1_valid;
  pixel_in_t  s1_pixel;
  conv_mode_t s1_mode;
  logic       s1_advance;
  logic       pixel_accept;

  parity_t    parity;
  conv_mode_t mode_next;
  pixel_out_t conv_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      sparse_chroma <= 1'b0;
      row_width     <= ROW_WIDTH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIRECTION:     direction     <= cfg_data[0];
        CFG_SPARSE_CHROMA: sparse_chroma <= cfg_data[0];
        CFG_ROW_WIDTH:     row_width     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake: input stage moves when the result register is free
  assign s1_advance   = s1_valid && (!result_valid || result_ready);
  assign pixel_ready  = !s1_valid || s1_advance;
  assign pixel_accept = pixel_valid && pixel_ready;

  // mode is fixed at acceptance, from the position of this pixel
  assign mode_next.inverse   = direction;
  assign mode_next.luma_only = direction && sparse_chroma &&
                               (parity.odd_column || parity.odd_row);

  rycc_position #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_position (
    .clk       (clk),
    .rst       (rst),
    .advance   (pixel_accept),
    .row_width (row_width),
    .parity    (parity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pixel <= pixel;
      s1_mode  <= mode_next;
    end
  end

  rycc_convert u_convert (
    .pixel  (s1_pixel),
    .mode   (s1_mode),
    .result (conv_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= conv_result;
    end
  end

  // checks
  `ASSERT_IMPLY(a_stall_blocks_input, clk, rst,
                s1_valid && result_valid && !result_ready, !pixel_ready)
  `ASSERT_NEXT(a_accept_fills_stage, clk, rst, pixel_accept, s1_valid)
  `ASSERT_IMPLY(a_luma_only_inverse, clk, rst,
                s1_valid && s1_mode.luma_only, s1_mode.inverse)
  `ASSERT_NEXT(a_luma_only_grey, clk, rst, s1_advance && s1_mode.luma_only,
               result.res0 == result.res1 && result.res1 == result.res2)

endmodule

// ===== rtl/rycc_position.sv =====
// Column counter and row/column parity tracker.
module rycc_position
  import rycc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [ROW_WIDTH_W-1:0] row_width,
  output parity_t                parity
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

  logic [CW-1:0] column_count;
  logic [WW-1:0] width_ext;
  logic [WW-1:0] width_eff;
  logic [WW-1:0] count_inc;
  logic          row_end;

  assign width_ext = WW'(row_width);
  assign count_inc = WW'(column_count) + WW'(1);
  assign row_end   = (count_inc >= width_eff);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      parity.odd_column <= 1'b0;
      parity.odd_row    <= 1'b0;
    end else if (advance) begin
      if (row_end) begin
        column_count      <= '0;
        parity.odd_column <= 1'b0;
        parity.odd_row    <= ~parity.odd_row;
      end else begin
        column_count      <= count_inc[CW-1:0];
        parity.odd_column <= ~parity.odd_column;
      end
    end
  end

endmodule

// ===== rtl/rycc_convert.sv =====
// Fixed-point colour conversion datapath, forward and inverse.
module rycc_convert
  import rycc_pkg::*;
(
  input  pixel_in_t  pixel,
  input  conv_mode_t mode,
  output pixel_out_t result
);

  logic signed [ACC_W-1:0] e0, e1, e2;
  logic signed [ACC_W-1:0] y_sum, cb_sum, cr_sum;
  logic signed [ACC_W-1:0] dr_sum, dg_sum, db_sum;
  logic signed [10:0]      r_pre, g_pre, b_pre;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] c;
    if (v < 11'sd0) begin
      c = 8'd0;
    end else if (v > 11'sd255) begin
      c = 8'd255;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

  assign e0 = signed'({18'd0, pixel.comp0});
  assign e1 = signed'({18'd0, pixel.comp1});
  assign e2 = signed'({18'd0, pixel.comp2});

  // forward sums stay in 0 .. (256 << 16) - 1
  assign y_sum  = K_Y_R * e0 + K_Y_G * e1 + K_Y_B * e2 + OFF_Y;
  assign cb_sum = K_CB_R * e0 + K_CB_G * e1 + K_HALF * e2 + OFF_C;
  assign cr_sum = K_HALF * e0 + K_CR_G * e1 + K_CR_B * e2 + OFF_C;

  // inverse chroma terms; bits [25:16] give the floor shift
  assign dr_sum = K_R_CR * e2 + OFF_R;
  assign dg_sum = K_G_CB * e1 + K_G_CR * e2 + OFF_G;
  assign db_sum = K_B_CB * e1 + OFF_B;

  assign r_pre = signed'({3'd0, pixel.comp0}) + 11'(signed'(dr_sum[25:16]));
  assign g_pre = signed'({3'd0, pixel.comp0}) + 11'(signed'(dg_sum[25:16]));
  assign b_pre = signed'({3'd0, pixel.comp0}) + 11'(signed'(db_sum[25:16]));

  always_comb begin
    result.alpha_out = pixel.alpha_in;
    if (!mode.inverse) begin
      result.res0 = y_sum[23:16];
      result.res1 = cb_sum[23:16];
      result.res2 = cr_sum[23:16];
    end else if (mode.luma_only) begin
      result.res0 = pixel.comp0;
      result.res1 = pixel.comp0;
      result.res2 = pixel.comp0;
    end else begin
      result.res0 = clamp_byte(r_pre);
      result.res1 = clamp_byte(g_pre);
      result.res2 = clamp_byte(b_pre);
    end
  end

endmodule
